### rtl/pcicfg_pkg.sv
`timescale 1ns / 1ps

package pcicfg_pkg;

	// default geometry of the config space
	localparam int CFG_BYTES_DEF = 256;
	localparam int NUM_BARS_DEF  = 6;

	// fixed layout of the type-0 header
	localparam int CMD_OFF       = 4;
	localparam int BAR_FIRST_OFF = 16;
	localparam int BAR_LAST_OFF  = 36;
	localparam int BAR_SLOTS     = 6;

	// input command codes
	localparam logic [2:0] CMD_ADDR_WR = 3'd0;
	localparam logic [2:0] CMD_ADDR_RD = 3'd1;
	localparam logic [2:0] CMD_DATA_WR = 3'd2;
	localparam logic [2:0] CMD_DATA_RD = 3'd3;
	localparam logic [2:0] CMD_LOOKUP  = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_DEVICE    = 3'd0;
	localparam logic [2:0] CFG_BAR0_SIZE = 3'd1;
	localparam logic [2:0] CFG_BAR1_SIZE = 3'd2;
	localparam logic [2:0] CFG_BAR2_SIZE = 3'd3;
	localparam logic [2:0] CFG_BAR3_SIZE = 3'd4;
	localparam logic [2:0] CFG_BAR4_SIZE = 3'd5;
	localparam logic [2:0] CFG_BAR5_SIZE = 3'd6;
	localparam logic [2:0] CFG_IO_MASK   = 3'd7;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_LOOKUP
	} state_t;

	// one accepted word, held for the execute cycle
	typedef struct packed {
		logic [2:0]  cmd;
		logic [1:0]  poff;
		logic [2:0]  nbytes;
		logic [31:0] wdata;
		logic [31:0] laddr;
		logic        lio;
	} item_t;

	// address bits kept by a bar of the given size, none when unimplemented
	function automatic logic [31:0] size_mask(input logic [4:0] k);
		return (k == 5'd0) ? 32'd0 : (32'hFFFF_FFFF << k);
	endfunction

endpackage

### rtl/pcicfg_ram.sv
`timescale 1ns / 1ps

module pcicfg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/pci_config_space_bar_decode.sv
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// in       input      in_valid / in_ready    command port_offset access_size write_data
//                                            lookup_address lookup_is_io
// out      output     out_valid / out_ready  read_data hit bar_index bar_offset
// cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// A port or config-space word is accepted in the idle state, which reads all four byte
// banks of the config memory; the execute state merges, writes back and loads the output.
// A decode lookup scans one bar per cycle until the first claim or the last bar.
// After reset a clearing pass zeroes the memory; no input word is taken meanwhile,
// config writes are. A waiting result holds its output register; the next word is
// still accepted and stalls in its execute cycle until the output frees.

module pci_config_space_bar_decode
	import pcicfg_pkg::*;
#(
	parameter int CONFIG_SPACE_BYTES = CFG_BYTES_DEF,
	parameter int NUM_BARS           = NUM_BARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [1:0]  port_offset,
	input  logic [2:0]  access_size,
	input  logic [31:0] write_data,
	input  logic [31:0] lookup_address,
	input  logic        lookup_is_io,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        hit,
	output logic [2:0]  bar_index,
	output logic [31:0] bar_offset,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	localparam int OFF_W   = $clog2(CONFIG_SPACE_BYTES);
	localparam int ROWS    = (CONFIG_SPACE_BYTES + 3) / 4;
	localparam int ROW_W   = OFF_W - 2;
	localparam int BIW     = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
	localparam int BAR_END = BAR_FIRST_OFF + 4 * NUM_BARS;

	state_t state_q, state_d;

	logic [ROW_W-1:0] clr_q;
	logic [BIW-1:0]   idx_q;
	logic             out_valid_q;

	logic [31:0]         latch_q, latch_d;
	logic [4:0]          device_q, device_d;
	logic [4:0]          size_q [BAR_SLOTS];
	logic [4:0]          size_d [BAR_SLOTS];
	logic [5:0]          io_mask_q, io_mask_d;
	logic [31:0]         bar_q [NUM_BARS];
	logic [31:0]         bar_d [NUM_BARS];
	logic [15:0]         cmd_q, cmd_d;
	logic [NUM_BARS-1:0] enabled_q, enabled_d;
	logic [NUM_BARS-1:0] claim_q, claim_d;

	item_t            item_s1;
	logic [OFF_W-1:0] off_s1;
	logic             hit_s1;

	logic [31:0] read_data_q;
	logic        hit_q;
	logic [2:0]  bar_index_q;
	logic [31:0] bar_offset_q;

	logic in_fire, out_free, exec_fire, out_load, idx_inc, clr_inc, clr_last;

	logic [2:0]       nbytes_in;
	logic [31:0]      cfg_addr, dev_base, off32;
	logic             in_space;
	logic [OFF_W-1:0] off_in;

	logic             bank_re;
	logic             bank_we    [4];
	logic [ROW_W-1:0] bank_waddr [4];
	logic [7:0]       bank_wdata [4];
	logic [ROW_W-1:0] bank_raddr [4];
	logic [7:0]       bank_rdata [4];

	logic [31:0] ex_rdata;
	logic        ex_hit;

	logic [31:0] lk_base, lk_diff;
	logic [4:0]  lk_size;
	logic        lk_match, lk_last;

	// row of the byte that lands in bank k for an access starting at off
	function automatic logic [ROW_W-1:0] lane_row(input logic [OFF_W-1:0] off,
	                                              input logic [1:0] k);
		logic [1:0]       j;
		logic [OFF_W-1:0] a;
		j = k - off[1:0];
		a = off + {{(OFF_W-2){1'b0}}, j};
		return a[OFF_W-1:2];
	endfunction

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign clr_last  = (clr_q == ROW_W'(ROWS - 1));
	assign lk_last   = (idx_q == BIW'(NUM_BARS - 1));

	// window check against the address latch at accept time
	always_comb begin
		nbytes_in = (access_size > 3'd4) ? 3'd4 : access_size;
		cfg_addr  = {latch_q[31:2], port_offset};
		dev_base  = {1'b1, 15'd0, device_q, 11'd0};
		off32     = cfg_addr - dev_base;
		in_space  = (cfg_addr >= dev_base) &&
		            (({1'b0, off32} + {30'd0, nbytes_in}) <= 33'(CONFIG_SPACE_BYTES));
		off_in    = off32[OFF_W-1:0];
	end

	// four byte banks, one row each per access
	assign bank_re = in_fire;

	always_comb begin
		logic [1:0] jk;
		for (int k = 0; k < 4; k++) begin
			jk            = 2'(k) - off_s1[1:0];
			bank_raddr[k] = lane_row(off_in, 2'(k));
			if (state_q == ST_CLEAR) begin
				bank_we[k]    = 1'b1;
				bank_waddr[k] = clr_q;
				bank_wdata[k] = 8'd0;
			end else begin
				bank_we[k]    = exec_fire && (item_s1.cmd == CMD_DATA_WR) && hit_s1 &&
				                ({1'b0, jk} < item_s1.nbytes);
				bank_waddr[k] = lane_row(off_s1, 2'(k));
				bank_wdata[k] = item_s1.wdata[{jk, 3'b000} +: 8];
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_bank
		pcicfg_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (bank_we[k]),
			.waddr(bank_waddr[k]),
			.wdata(bank_wdata[k]),
			.re   (bank_re),
			.raddr(bank_raddr[k]),
			.rdata(bank_rdata[k])
		);
	end

	// result of a port or config-space word
	always_comb begin
		logic [2:0]       pb;
		logic [OFF_W-1:0] a;
		logic [OFF_W-1:0] rel;
		logic [7:0]       bv;
		ex_rdata = 32'd0;
		ex_hit   = 1'b0;
		unique case (item_s1.cmd)
			CMD_ADDR_RD: begin
				for (int j = 0; j < 4; j++) begin
					pb = {1'b0, item_s1.poff} + 3'(j);
					if ((3'(j) < item_s1.nbytes) && (pb <= 3'd3)) begin
						ex_rdata[8*j +: 8] = latch_q[{pb[1:0], 3'b000} +: 8];
					end
				end
			end
			CMD_DATA_WR: begin
				ex_hit = hit_s1;
			end
			CMD_DATA_RD: begin
				if (hit_s1) begin
					ex_hit = 1'b1;
					for (int j = 0; j < 4; j++) begin
						a   = off_s1 + OFF_W'(j);
						rel = a - OFF_W'(BAR_FIRST_OFF);
						bv  = bank_rdata[a[1:0]];
						// command word and bars live in flops
						if (a == OFF_W'(CMD_OFF)) begin
							bv = cmd_q[7:0];
						end else if (a == OFF_W'(CMD_OFF + 1)) begin
							bv = cmd_q[15:8];
						end else if ((a >= OFF_W'(BAR_FIRST_OFF)) && (a < OFF_W'(BAR_END))) begin
							bv = bar_q[rel[BIW+1:2]][{a[1:0], 3'b000} +: 8];
						end
						if (3'(j) < item_s1.nbytes) begin
							ex_rdata[8*j +: 8] = bv;
						end
					end
				end else begin
					ex_rdata = 32'hFFFF_FFFF;
				end
			end
			default: begin
			end
		endcase
	end

	// decode lookup, one bar per cycle
	always_comb begin
		lk_base  = bar_q[idx_q] & ~32'd1;
		lk_diff  = item_s1.laddr - lk_base;
		lk_size  = size_q[3'(idx_q)];
		lk_match = claim_q[idx_q] && (io_mask_q[3'(idx_q)] == item_s1.lio) &&
		           (item_s1.laddr >= lk_base) && ((lk_diff >> lk_size) == 32'd0);
	end

	// state update from execute and config writes
	always_comb begin
		logic [2:0]       pb;
		logic [2:0]       rb;
		logic [2:0]       slot;
		logic [OFF_W-1:0] a;
		logic [OFF_W-1:0] rel;
		logic [7:0]       bv;
		logic             en;
		latch_d   = latch_q;
		device_d  = device_q;
		size_d    = size_q;
		io_mask_d = io_mask_q;
		bar_d     = bar_q;
		cmd_d     = cmd_q;
		enabled_d = enabled_q;
		claim_d   = claim_q;

		if (exec_fire) begin
			unique case (item_s1.cmd)
				CMD_ADDR_WR: begin
					for (int j = 0; j < 4; j++) begin
						pb = {1'b0, item_s1.poff} + 3'(j);
						if ((3'(j) < item_s1.nbytes) && (pb <= 3'd3)) begin
							latch_d[{pb[1:0], 3'b000} +: 8] = item_s1.wdata[8*j +: 8];
						end
					end
					latch_d[1:0] = 2'b00;
				end
				CMD_ADDR_RD: begin
					latch_d[1:0] = 2'b00;
				end
				CMD_DATA_WR: begin
					if (hit_s1) begin
						// bytes that land in the command word or a bar
						for (int j = 0; j < 4; j++) begin
							a   = off_s1 + OFF_W'(j);
							rel = a - OFF_W'(BAR_FIRST_OFF);
							bv  = item_s1.wdata[8*j +: 8];
							if (3'(j) < item_s1.nbytes) begin
								if (a == OFF_W'(CMD_OFF)) begin
									cmd_d[7:0] = bv;
								end else if (a == OFF_W'(CMD_OFF + 1)) begin
									cmd_d[15:8] = bv;
								end else if ((a >= OFF_W'(BAR_FIRST_OFF)) &&
								             (a < OFF_W'(BAR_END))) begin
									bar_d[rel[BIW+1:2]][{a[1:0], 3'b000} +: 8] = bv;
								end
							end
						end
						// write starting inside a bar: size it and keep the space bit
						rel = off_s1 - OFF_W'(BAR_FIRST_OFF);
						rb  = rel[4:2];
						if ((off_s1 >= OFF_W'(BAR_FIRST_OFF)) &&
						    (off_s1 <= OFF_W'(BAR_LAST_OFF)) && (rb < 3'(NUM_BARS))) begin
							bar_d[rb[BIW-1:0]] = (bar_d[rb[BIW-1:0]] & size_mask(size_q[rb])) |
							                     {31'd0, io_mask_q[rb]};
						end
						// write starting at the command word: re-evaluate decode
						if (off_s1 == OFF_W'(CMD_OFF)) begin
							for (int i = 0; i < NUM_BARS; i++) begin
								en = io_mask_q[i] ? cmd_d[0] : cmd_d[1];
								if (en) begin
									if (!enabled_q[i] &&
									    ((bar_d[i] & ~32'd1 & size_mask(size_q[i])) != 32'd0)) begin
										claim_d[i] = 1'b1;
									end
									enabled_d[i] = 1'b1;
								end else begin
									claim_d[i]   = 1'b0;
									enabled_d[i] = 1'b0;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (cfg_valid) begin
			slot = cfg_index - CFG_BAR0_SIZE;
			unique case (cfg_index)
				CFG_DEVICE: begin
					device_d = cfg_data[4:0];
				end
				CFG_BAR0_SIZE, CFG_BAR1_SIZE, CFG_BAR2_SIZE,
				CFG_BAR3_SIZE, CFG_BAR4_SIZE, CFG_BAR5_SIZE: begin
					size_d[slot] = cfg_data[4:0];
					if (slot < 3'(NUM_BARS)) begin
						bar_d[slot[BIW-1:0]]   = {31'd0, io_mask_q[slot]};
						claim_d[slot[BIW-1:0]] = 1'b0;
					end
				end
				CFG_IO_MASK: begin
					io_mask_d = cfg_data;
					for (int i = 0; i < NUM_BARS; i++) begin
						bar_d[i] = {31'd0, cfg_data[i]};
					end
					claim_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		exec_fire = 1'b0;
		out_load  = 1'b0;
		idx_inc   = 1'b0;
		clr_inc   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				clr_inc = 1'b1;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (command == CMD_LOOKUP) ? ST_LOOKUP : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					exec_fire = 1'b1;
					out_load  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_LOOKUP: begin
				if (lk_match || lk_last) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			latch_q     <= 32'd0;
			device_q    <= 5'd0;
			io_mask_q   <= 6'd0;
			cmd_q       <= 16'd0;
			enabled_q   <= '0;
			claim_q     <= '0;
			for (int i = 0; i < BAR_SLOTS; i++) begin
				size_q[i] <= 5'd0;
			end
			for (int i = 0; i < NUM_BARS; i++) begin
				bar_q[i] <= 32'd0;
			end
		end else begin
			state_q <= state_d;
			if (clr_inc) begin
				clr_q <= clr_q + 1'b1;
			end
			if (in_fire) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			latch_q   <= latch_d;
			device_q  <= device_d;
			io_mask_q <= io_mask_d;
			cmd_q     <= cmd_d;
			enabled_q <= enabled_d;
			claim_q   <= claim_d;
			size_q    <= size_d;
			bar_q     <= bar_d;
		end
	end

	// accepted word for the execute cycle
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.cmd    <= command;
			item_s1.poff   <= port_offset;
			item_s1.nbytes <= nbytes_in;
			item_s1.wdata  <= write_data;
			item_s1.laddr  <= lookup_address;
			item_s1.lio    <= lookup_is_io;
			off_s1         <= off_in;
			hit_s1         <= in_space;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_LOOKUP) begin
				read_data_q  <= 32'd0;
				hit_q        <= lk_match;
				bar_index_q  <= lk_match ? 3'(idx_q) : 3'd0;
				bar_offset_q <= lk_match ? lk_diff : 32'd0;
			end else begin
				read_data_q  <= ex_rdata;
				hit_q        <= ex_hit;
				bar_index_q  <= 3'd0;
				bar_offset_q <= 32'd0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign hit        = hit_q;
	assign bar_index  = bar_index_q;
	assign bar_offset = bar_offset_q;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import pcicfg_pkg::*;

	localparam int SPACE_BYTES = CFG_BYTES_DEF;
	localparam int NBARS       = NUM_BARS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 400;

	// command codes the block ignores
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [31:0] rdata;
		logic        hit;
		logic [2:0]  bidx;
		logic [31:0] boff;
	} cfg_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = CMD_ADDR_WR;
	logic [1:0]  port_offset = '0;
	logic [2:0]  access_size = '0;
	logic [31:0] write_data = '0;
	logic [31:0] lookup_address = '0;
	logic        lookup_is_io = 1'b0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic        hit;
	logic [2:0]  bar_index;
	logic [31:0] bar_offset;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_DEVICE;
	logic [5:0]  cfg_data = '0;

	pci_config_space_bar_decode dut (.*);

	always #5 clk = ~clk;

	// shadow copy of the device: latch, header bytes, decode state, registers
	logic [31:0] sh_latch;
	logic [7:0]  sh_space [SPACE_BYTES];
	logic [5:0]  sh_enabled;
	logic [5:0]  sh_claim;
	logic [4:0]  sh_dev;
	logic [4:0]  sh_size [NBARS];
	logic [5:0]  sh_io;

	item_t       pending_words [$];
	cfg_reply_t  due_replies [$];
	item_t       cur_word;
	logic        word_taken = 1'b0;
	logic        quiet = 1'b0;
	logic        long_hold_req = 1'b0;
	int          hold_left = 0;
	int          mismatches = 0;
	int          cycles = 0;
	logic [31:0] planned_base [NBARS];

	function automatic logic [31:0] decode_mask(int i);
		if (sh_size[i] == 5'd0)
			return 32'd0;
		return ~((32'd1 << sh_size[i]) - 32'd1);
	endfunction

	function automatic logic [31:0] bar_word(int i);
		int b;
		b = BAR_FIRST_OFF + 4 * i;
		return {sh_space[b + 3], sh_space[b + 2], sh_space[b + 1], sh_space[b]};
	endfunction

	function automatic void set_bar_word(int i, logic [31:0] v);
		int b;
		int j;
		b = BAR_FIRST_OFF + 4 * i;
		for (j = 0; j < 4; j++)
			sh_space[b + j] = v[8 * j +: 8];
	endfunction

	function automatic void clear_bar(int i);
		set_bar_word(i, {31'd0, sh_io[i]});
		sh_claim[i] = 1'b0;
	endfunction

	function automatic void reset_shadow();
		int i;
		sh_latch = '0;
		for (i = 0; i < SPACE_BYTES; i++)
			sh_space[i] = 8'd0;
		sh_enabled = '0;
		sh_claim = '0;
		sh_dev = '0;
		sh_io = '0;
		for (i = 0; i < NBARS; i++) begin
			sh_size[i] = 5'd0;
			clear_bar(i);
		end
	endfunction

	// command word: bit 0 gates io bars, bit 1 memory bars
	function automatic void reeval_decode();
		logic [15:0] cw;
		logic        en;
		logic [31:0] base;
		int          i;
		cw = {sh_space[CMD_OFF + 1], sh_space[CMD_OFF]};
		for (i = 0; i < NBARS; i++) begin
			en = sh_io[i] ? cw[0] : cw[1];
			if (en) begin
				base = bar_word(i) & ~32'd1;
				if (!sh_enabled[i] && (base & decode_mask(i)) != 32'd0)
					sh_claim[i] = 1'b1;
				sh_enabled[i] = 1'b1;
			end else begin
				sh_claim[i] = 1'b0;
				sh_enabled[i] = 1'b0;
			end
		end
	endfunction

	function automatic void apply_cfg_write(logic [2:0] idx, logic [5:0] val);
		int bi;
		int i;
		case (idx)
			CFG_DEVICE: begin
				sh_dev = val[4:0];
			end
			CFG_BAR0_SIZE, CFG_BAR1_SIZE, CFG_BAR2_SIZE,
			CFG_BAR3_SIZE, CFG_BAR4_SIZE, CFG_BAR5_SIZE: begin
				bi = int'(idx - CFG_BAR0_SIZE);
				sh_size[bi] = val[4:0];
				clear_bar(bi);
			end
			default: begin
				sh_io = val;
				for (i = 0; i < NBARS; i++)
					clear_bar(i);
			end
		endcase
	endfunction

	// one port access or lookup against the shadow, returns the reply it causes
	function automatic cfg_reply_t cfg_space_access(item_t w);
		cfg_reply_t  r;
		int          n;
		int          b;
		int          j;
		int          i;
		int          bi;
		logic [31:0] addr;
		logic [31:0] dbase;
		logic [31:0] off;
		logic [31:0] base;
		logic [63:0] span;
		r = '0;
		n = (w.nbytes > 3'd4) ? 4 : int'(w.nbytes);
		case (w.cmd)
			CMD_ADDR_WR, CMD_ADDR_RD: begin
				for (j = 0; j < n; j++) begin
					b = int'(w.poff) + j;
					if (b > 3)
						break;
					if (w.cmd == CMD_ADDR_WR)
						sh_latch[8 * b +: 8] = w.wdata[8 * j +: 8];
					else
						r.rdata[8 * j +: 8] = sh_latch[8 * b +: 8];
				end
				sh_latch[1:0] = 2'b00;
			end
			CMD_DATA_WR, CMD_DATA_RD: begin
				addr = sh_latch | {30'd0, w.poff};
				dbase = 32'h8000_0000 | {16'd0, sh_dev, 11'd0};
				off = addr - dbase;
				if (addr >= dbase && ({32'd0, off} + 64'(n)) <= 64'(SPACE_BYTES)) begin
					r.hit = 1'b1;
					if (w.cmd == CMD_DATA_WR) begin
						for (j = 0; j < n; j++)
							sh_space[off + j] = w.wdata[8 * j +: 8];
						if (off == CMD_OFF) begin
							reeval_decode();
						end else if (off >= BAR_FIRST_OFF && off <= BAR_LAST_OFF) begin
							bi = int'((off - BAR_FIRST_OFF) >> 2);
							if (bi < NBARS)
								set_bar_word(bi, (bar_word(bi) & decode_mask(bi)) |
									{31'd0, sh_io[bi]});
						end
					end else begin
						for (j = 0; j < n; j++)
							r.rdata[8 * j +: 8] = sh_space[off + j];
					end
				end else if (w.cmd == CMD_DATA_RD) begin
					r.rdata = '1;
				end
			end
			CMD_LOOKUP: begin
				for (i = 0; i < NBARS; i++) begin
					if (sh_claim[i] && sh_io[i] == w.lio) begin
						base = bar_word(i) & ~32'd1;
						span = 64'd1 << sh_size[i];
						if (w.laddr >= base && {32'd0, w.laddr - base} < span) begin
							r.hit = 1'b1;
							r.bidx = 3'(i);
							r.boff = w.laddr - base;
							break;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] window_addr(int reg_off);
		return 32'h8000_0000 | {16'd0, sh_dev, 11'd0} | 32'(reg_off);
	endfunction

	// mostly legal widths, now and then an odd one
	function automatic logic [2:0] pick_size();
		case ($urandom_range(9))
			0: return 3'($urandom_range(7));
			1, 2, 3: return 3'd1;
			4, 5, 6: return 3'd2;
			default: return 3'd4;
		endcase
	endfunction

	// bar size with a random unused top bit, extremes favored
	function automatic logic [5:0] pick_bar_size();
		logic [4:0] k;
		case ($urandom_range(9))
			0: k = 5'd0;
			1: k = 5'd31;
			default: k = 5'($urandom_range(30, 1));
		endcase
		return {1'($urandom_range(1)), k};
	endfunction

	task automatic queue_word(input logic [2:0] cmd, input logic [1:0] poff,
		input logic [2:0] nbytes, input logic [31:0] wd, input logic [31:0] la,
		input logic lio);
		item_t w;
		w.cmd = cmd;
		w.poff = poff;
		w.nbytes = nbytes;
		w.wdata = wd;
		w.laddr = la;
		w.lio = lio;
		pending_words.push_back(w);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [5:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_cfg_write(idx, val);
	endtask

	// sizes holds bar N in bits 6N+5:6N
	task automatic program_regs(input logic [5:0] dev, input logic [35:0] sizes,
		input logic [5:0] io);
		int i;
		write_reg(CFG_DEVICE, dev);
		for (i = 0; i < NBARS; i++)
			write_reg(CFG_BAR0_SIZE + 3'(i), sizes[6 * i +: 6]);
		write_reg(CFG_IO_MASK, io);
		@(negedge clk);
		cfg_valid <= 1'b0;
		for (i = 0; i < NBARS; i++)
			planned_base[i] = 32'd0;
	endtask

	task automatic wait_quiet();
		while (pending_words.size() > 0 || in_valid || due_replies.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// random traffic, mostly latch-then-access pairs that reach the header
	task automatic gen_traffic(input int count);
		int          made;
		int          pick;
		int          i;
		int          reg_off;
		logic [31:0] v;
		logic [31:0] fill;
		logic [31:0] la;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 28) begin
				// place a bar at a random base
				i = $urandom_range(NBARS - 1);
				v = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
				queue_word(CMD_ADDR_WR, 2'd0, 3'd4, window_addr(BAR_FIRST_OFF + 4 * i),
					32'($urandom), 1'($urandom_range(1)));
				queue_word(CMD_DATA_WR, 2'd0, 3'd4, v, 32'($urandom), 1'($urandom_range(1)));
				planned_base[i] = v & decode_mask(i);
				made += 2;
			end else if (pick < 42) begin
				// toggle io and memory decode
				v = ($urandom_range(7) == 0) ? 32'($urandom) : 32'($urandom_range(3));
				queue_word(CMD_ADDR_WR, 2'd0, 3'd4, window_addr(CMD_OFF), 32'($urandom),
					1'($urandom_range(1)));
				queue_word(CMD_DATA_WR, 2'd0, pick_size(), v, 32'($urandom),
					1'($urandom_range(1)));
				made += 2;
			end else if (pick < 68) begin
				// lookup in and around a planned window
				i = $urandom_range(NBARS - 1);
				fill = (sh_size[i] == 5'd0) ? 32'd0 : (32'hFFFF_FFFF >> (32 - sh_size[i]));
				case ($urandom_range(9))
					0: la = planned_base[i] - 32'd1;
					1: la = planned_base[i] + fill + 32'd1;
					2: la = planned_base[i] + fill;
					default: la = planned_base[i] + (32'($urandom) & fill);
				endcase
				queue_word(CMD_LOOKUP, 2'($urandom_range(3)), 3'($urandom_range(7)),
					32'($urandom), la, ($urandom_range(9) == 0) ? ~sh_io[i] : sh_io[i]);
				made += 1;
			end else if (pick < 85) begin
				// header access, mostly inside the window, some near its end
				case ($urandom_range(3))
					0: reg_off = $urandom_range(255, 248);
					1: reg_off = $urandom_range(7);
					default: reg_off = $urandom_range(255);
				endcase
				la = window_addr(reg_off);
				if ($urandom_range(6) == 0)
					la = ($urandom_range(1) == 0) ? 32'($urandom) : (la ^ 32'h0000_0800);
				queue_word(CMD_ADDR_WR, 2'd0, 3'd4, la, 32'($urandom), 1'($urandom_range(1)));
				queue_word(($urandom_range(1) == 0) ? CMD_DATA_RD : CMD_DATA_WR,
					2'($urandom_range(3)), pick_size(), 32'($urandom), 32'($urandom),
					1'($urandom_range(1)));
				made += 2;
			end else begin
				// anything at all
				queue_word(3'($urandom_range(7)), 2'($urandom_range(3)),
					3'($urandom_range(7)), 32'($urandom), 32'($urandom),
					1'($urandom_range(1)));
				made += 1;
			end
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	// sender: offer the next word once the previous one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || word_taken)) begin
			if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 26)) begin
				cur_word = pending_words.pop_front();
				command <= cur_word.cmd;
				port_offset <= cur_word.poff;
				access_size <= cur_word.nbytes;
				write_data <= cur_word.wdata;
				lookup_address <= cur_word.laddr;
				lookup_is_io <= cur_word.lio;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		word_taken = 1'b0;
	end

	// predict the reply of every accepted word
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			due_replies.push_back(cfg_space_access(cur_word));
			word_taken = 1'b1;
		end
	end

	// receiver: random back-pressure, one long hold on request
	always @(negedge clk) begin
		if (long_hold_req) begin
			hold_left = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= quiet || ($urandom_range(99) >= 26);
		end
	end

	// compare each reply word with the oldest prediction
	always @(posedge clk) begin
		cfg_reply_t want;
		if (out_valid && out_ready) begin
			if (due_replies.size() == 0) begin
				mismatches++;
				$display("%0t: reply with none predicted, expected nothing, actual %h %b %h %h",
					$time, read_data, hit, bar_index, bar_offset);
			end else begin
				want = due_replies.pop_front();
				check_field("read_data", want.rdata, read_data);
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("bar_index", 32'(want.bidx), 32'(bar_index));
				check_field("bar_offset", want.boff, bar_offset);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] win;
		reset_shadow();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: device 31, mixed bar sizes, bars 0 and 2 in io space
		program_regs(6'h3F, {6'd0, 6'd16, 6'd1, 6'd8, 6'd31, 6'd4}, 6'b000101);
		win = window_addr(0);
		queue_word(CMD_ADDR_WR, 2'd0, 3'd4, win | 32'h10, '0, 1'b0);
		queue_word(CMD_DATA_WR, 2'd0, 3'd4, 32'hFFFF_FFFF, '0, 1'b0);
		queue_word(CMD_DATA_RD, 2'd0, 3'd4, '0, '0, 1'b0);
		queue_word(CMD_ADDR_WR, 2'd0, 3'd4, win | 32'h14, '0, 1'b0);
		queue_word(CMD_DATA_WR, 2'd0, 3'd4, 32'hC000_0000, '0, 1'b0);
		queue_word(CMD_ADDR_WR, 2'd0, 3'd4, win | 32'h04, '0, 1'b0);
		queue_word(CMD_DATA_WR, 2'd0, 3'd2, 32'h0000_0003, '0, 1'b0);
		queue_word(CMD_LOOKUP, 2'd0, 3'd4, '0, 32'hFFFF_FFFF, 1'b1);
		queue_word(CMD_LOOKUP, 2'd0, 3'd4, '0, 32'hFFFF_FFFF, 1'b0);
		queue_word(CMD_LOOKUP, 2'd0, 3'd4, '0, 32'h7FFF_FFFF, 1'b0);
		queue_word(CMD_ADDR_RD, 2'd3, 3'd4, '0, '0, 1'b0);
		queue_word(CMD_ADDR_WR, 2'd2, 3'd4, 32'hAABB_CCDD, '0, 1'b0);
		queue_word(CMD_DATA_RD, 2'd3, 3'd2, '0, '0, 1'b0);
		queue_word(CMD_ADDR_WR, 2'd0, 3'd4, win | 32'hFC, '0, 1'b0);
		queue_word(CMD_DATA_RD, 2'd3, 3'd1, '0, '0, 1'b0);
		queue_word(CMD_DATA_RD, 2'd2, 3'd4, '0, '0, 1'b0);
		queue_word(CMD_DATA_WR, 2'd3, 3'd0, 32'h5A5A_5A5A, '0, 1'b0);
		queue_word(CMD_ADDR_WR, 2'd0, 3'd7, win | 32'h04, '0, 1'b0);
		queue_word(CMD_DATA_WR, 2'd0, 3'd0, '0, '0, 1'b0);
		queue_word(CMD_SPARE_LO, 2'd3, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		queue_word(CMD_SPARE_HI, 2'd1, 3'd2, 32'h1234_5678, 32'h8765_4321, 1'b0);
		queue_word(CMD_DATA_WR, 2'd0, 3'd1, '0, '0, 1'b0);
		queue_word(CMD_LOOKUP, 2'd0, 3'd4, '0, 32'hFFFF_FFF0, 1'b1);
		queue_word(CMD_ADDR_WR, 2'd0, 3'd4, '0, '0, 1'b0);
		queue_word(CMD_DATA_RD, 2'd0, 3'd4, '0, '0, 1'b0);
		wait_quiet();

		// small bars of sizes 1 to 6, all memory space, device 0
		program_regs(6'h00, {6'd6, 6'd5, 6'd4, 6'd3, 6'd2, 6'd1}, 6'h00);
		gen_traffic(280);
		wait_quiet();

		// largest bars, all io space, no idling at all
		quiet = 1'b1;
		program_regs(6'h1F, {6'd31, 6'd31, 6'd31, 6'd31, 6'd31, 6'd31}, 6'h3F);
		gen_traffic(250);
		wait_quiet();
		quiet = 1'b0;

		// random setting, receiver holds off long enough to back up the input
		program_regs(6'($urandom), {pick_bar_size(), pick_bar_size(), pick_bar_size(),
			pick_bar_size(), pick_bar_size(), pick_bar_size()}, 6'($urandom));
		long_hold_req = 1'b1;
		gen_traffic(300);
		wait_quiet();

		// random setting, sender pauses halfway until all replies are in
		program_regs(6'($urandom), {pick_bar_size(), pick_bar_size(), pick_bar_size(),
			pick_bar_size(), pick_bar_size(), pick_bar_size()}, 6'($urandom));
		gen_traffic(150);
		wait_quiet();
		gen_traffic(150);
		wait_quiet();

		// random setting
		program_regs(6'($urandom), {pick_bar_size(), pick_bar_size(), pick_bar_size(),
			pick_bar_size(), pick_bar_size(), pick_bar_size()}, 6'($urandom));
		gen_traffic(250);
		wait_quiet();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
rtl/pcicfg_pkg.sv
rtl/pcicfg_ram.sv
rtl/pci_config_space_bar_decode.sv
tb/tb.sv
